/* rtl/isil_pkg.sv */
// Shared constants and the result type of the I2C slave image loader.
`default_nettype none

package isil_pkg;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  localparam logic [7:0] BYTE_CONNECT = 8'hef;
  localparam logic [7:0] BYTE_BUSY    = 8'h78;
  localparam logic [7:0] BYTE_OK      = 8'h46;
  localparam logic [7:0] BYTE_FATAL   = 8'h45;
  localparam logic [7:0] BYTE_IDLE    = 8'h00;
  localparam logic [7:0] BYTE_NOFLASH = 8'h59;
  localparam logic [7:0] BYTE_FLASH   = 8'h58;

  localparam logic [2:0] FIELD_BYTES = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLEAR = 2'd1;
  localparam logic [1:0] EV_OK    = 2'd2;
  localparam logic [1:0] EV_FATAL = 2'd3;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        store_valid;
    logic [31:0] store_index;
    logic [7:0]  store_byte;
    logic [1:0]  status_event;
    logic [2:0]  phase;
    logic        flash_request;
    logic        done_res;
  } result_t;

endpackage

`default_nettype wire

/* rtl/isil_core.sv */
// Download protocol state and the per-request update logic of the image loader.
`default_nettype none

module isil_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic [1:0]           func,
  input  logic [7:0]           data_byte,
  output isil_pkg::result_t    res
);

  typedef enum logic [2:0] {
    PH_FINISH   = 3'd0,
    PH_CONNECT  = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_FILE     = 3'd3,
    PH_ACK      = 3'd4,
    PH_ERROR    = 3'd5,
    PH_CHECKSUM = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] expected_sum, expected_sum_next;
  logic [31:0] image_length, image_length_next;
  logic [2:0]  field_count, field_count_next;
  logic [31:0] image_index, image_index_next;
  logic [31:0] running_sum, running_sum_next;
  logic        sum_failed, sum_failed_next;
  logic        flash_flag, flash_flag_next;

  logic [2:0]  count_inc;
  logic        store_now;
  logic [31:0] index_after;
  logic [31:0] sum_after;
  logic        image_complete;

  assign count_inc      = field_count + 3'd1;
  assign store_now      = image_index < image_length;
  assign index_after    = store_now ? image_index + 32'd1 : image_index;
  assign sum_after      = store_now ? running_sum + {24'd0, data_byte} : running_sum;
  assign image_complete = !(index_after < image_length);

  always_comb begin
    phase_next        = phase;
    expected_sum_next = expected_sum;
    image_length_next = image_length;
    field_count_next  = field_count;
    image_index_next  = image_index;
    running_sum_next  = running_sum;
    sum_failed_next   = sum_failed;
    flash_flag_next   = flash_flag;
    res               = '0;

    if (phase != PH_FINISH) begin
      unique case (func)
        isil_pkg::FUNC_BYTE: begin
          unique case (phase)
            PH_CONNECT: begin
              if (data_byte == isil_pkg::BYTE_CONNECT) begin
                phase_next = PH_CHECKSUM;
              end
            end
            PH_CHECKSUM: begin
              expected_sum_next = {data_byte, expected_sum[31:8]};
              field_count_next  = count_inc;
              if (count_inc == isil_pkg::FIELD_BYTES) begin
                phase_next       = PH_LENGTH;
                field_count_next = 3'd0;
                res.status_event = isil_pkg::EV_CLEAR;
              end
            end
            PH_LENGTH: begin
              image_length_next = {data_byte, image_length[31:8]};
              field_count_next  = count_inc;
              if (count_inc == isil_pkg::FIELD_BYTES) begin
                phase_next = PH_FILE;
              end
            end
            PH_FILE: begin
              if (store_now) begin
                res.store_valid = 1'b1;
                res.store_index = image_index;
                res.store_byte  = data_byte;
              end
              image_index_next = index_after;
              running_sum_next = sum_after;
              if (image_complete) begin
                if (sum_after == expected_sum) begin
                  phase_next       = PH_ACK;
                  res.status_event = isil_pkg::EV_OK;
                end else begin
                  sum_failed_next   = 1'b1;
                  phase_next        = PH_CHECKSUM;
                  image_length_next = 32'd0;
                  field_count_next  = 3'd0;
                  image_index_next  = 32'd0;
                  running_sum_next  = 32'd0;
                  res.status_event  = isil_pkg::EV_FATAL;
                end
              end
            end
            PH_ACK: begin
              if (data_byte == isil_pkg::BYTE_FLASH) begin
                flash_flag_next  = 1'b1;
                phase_next       = PH_FINISH;
                res.status_event = isil_pkg::EV_CLEAR;
              end else if (data_byte == isil_pkg::BYTE_NOFLASH) begin
                flash_flag_next  = 1'b0;
                phase_next       = PH_FINISH;
                res.status_event = isil_pkg::EV_CLEAR;
              end
            end
            default: begin
            end
          endcase
        end
        isil_pkg::FUNC_READ: begin
          res.reply_valid = 1'b1;
          unique case (phase) inside
            PH_CHECKSUM, PH_LENGTH, PH_FILE: begin
              if (sum_failed) begin
                res.reply_byte  = isil_pkg::BYTE_FATAL;
                sum_failed_next = 1'b0;
              end else begin
                res.reply_byte = isil_pkg::BYTE_BUSY;
              end
            end
            PH_ERROR: begin
              res.reply_byte = isil_pkg::BYTE_FATAL;
              phase_next     = PH_LENGTH;
            end
            PH_ACK: begin
              res.reply_byte = isil_pkg::BYTE_OK;
            end
            default: begin
              res.reply_byte = isil_pkg::BYTE_IDLE;
            end
          endcase
        end
        isil_pkg::FUNC_ABORT: begin
          phase_next = PH_ERROR;
        end
        default: begin
        end
      endcase
    end

    res.phase         = phase_next;
    res.flash_request = flash_flag_next;
    res.done_res      = (phase_next == PH_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CONNECT;
      expected_sum <= 32'd0;
      image_length <= 32'd0;
      field_count  <= 3'd0;
      image_index  <= 32'd0;
      running_sum  <= 32'd0;
      sum_failed   <= 1'b0;
      flash_flag   <= 1'b0;
    end else if (step_en) begin
      phase        <= phase_next;
      expected_sum <= expected_sum_next;
      image_length <= image_length_next;
      field_count  <= field_count_next;
      image_index  <= image_index_next;
      running_sum  <= running_sum_next;
      sum_failed   <= sum_failed_next;
      flash_flag   <= flash_flag_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2c_slave_image_loader_core.sv */
// Top level of the I2C slave image loader: request register, protocol core, result register.
//
// Each input request is one slave event: func 0 carries a received byte in data_byte,
// func 1 is a read request from the master and func 2 a transmit abort. Every request
// yields exactly one result carrying the reply byte, an optional image store, a mailbox
// status event and the current phase, flash request and done flags.
// Both channels use valid and ready. A request is held in an input register and is
// processed in the cycle it moves into the result register, from which its result is
// offered. One request per cycle is sustained while the receiver takes every result.
// When the receiver stalls, the result register holds its value and one further request
// is still taken into the input register; after that in_ready falls until the result is
// taken. Reset clears the valid flags of both registers and returns the protocol to
// waiting for the connect byte with all counters, sums and flags cleared. Once the
// download has finished, every request is answered with a result that carries no reply,
// store or status event, with done set, until the next reset.
`default_nettype none

module i2c_slave_image_loader_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reply_valid,
  output logic [7:0]  reply_byte,
  output logic        store_valid,
  output logic [31:0] store_index,
  output logic [7:0]  store_byte,
  output logic [1:0]  status_event,
  output logic [2:0]  phase,
  output logic        flash_request,
  output logic        done_res
);

  logic              req_valid;
  logic [1:0]        req_func;
  logic [7:0]        req_byte;
  logic              advance;
  isil_pkg::result_t step_res;
  isil_pkg::result_t res;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  isil_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .func      (req_func),
    .data_byte (req_byte),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= req_valid;
      end
    end
    if (in_valid && in_ready) begin
      req_func <= func;
      req_byte <= data_byte;
    end
    if (advance) begin
      res <= step_res;
    end
  end

  assign reply_valid   = res.reply_valid;
  assign reply_byte    = res.reply_byte;
  assign store_valid   = res.store_valid;
  assign store_index   = res.store_index;
  assign store_byte    = res.store_byte;
  assign status_event  = res.status_event;
  assign phase         = res.phase;
  assign flash_request = res.flash_request;
  assign done_res      = res.done_res;

endmodule

`default_nettype wire
